[hdl/tgpg_pkg.sv]
// Package for the trot gait phase generator: field widths, beat layouts,
// configuration register indexes and reset values. No dependencies.
package tgpg_pkg;

    // field widths
    localparam int NOW_W   = 32;
    localparam int SPEED_W = 16;
    localparam int STEP_W  = 20;
    localparam int SWING_W = 16;
    localparam int PHASE_W = 16;

    // beat layouts
    localparam int S_TDATA_W = 48;            // now_ms, target_speed_mm_s
    localparam int M_TDATA_W = 8 * PHASE_W;   // four stance, then four swing

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = STEP_W;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWING_PERIOD = 1'b1;
    localparam logic [STEP_W-1:0]  STEP_LENGTH_RST  = 20'd100000;
    localparam logic [SWING_W-1:0] SWING_PERIOD_RST = 16'd250;

    // datapath widths
    localparam int WV_W   = SWING_W + SPEED_W;     // swing period times speed
    localparam int PROD_W = NOW_W + SPEED_W;       // elapsed time times speed
    localparam int SUM_W  = WV_W + 1;              // step length plus W*v
    localparam int C_W    = SUM_W + 3;             // signed, doubled leg clock
    localparam int DIV_W  = SUM_W + 2;             // divider remainder

    // serial step counter, 16 steps for both multiply and divide
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SPEED_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PHASE_W - 1);

    // Q0.16 one half
    localparam logic [PHASE_W-1:0] PHASE_HALF = 16'h8000;

endpackage

[hdl/trot_gait_phase_generator_unit.sv]
// Trot gait phase generator, top level: bit-serial multiplier, restoring
// divider shared by both leg pairs, and the gait state.
// Depends on tgpg_pkg.
//
//  channel   direction  beat contents (lowest bit up)
//  s_        in         now_ms[31:0], target_speed_mm_s[47:32]
//  m_        out        stance_leg0..3 [63:0], swing_leg0..3 [127:64]
//  cfg_      in         wr_en, addr (0 step_length_um, 1 swing_period_ms)
//
// Sequence: a nonzero-speed beat runs from accept to the next accept through
//   the shift-add multiply (one speed bit per cycle), the restart compare,
//   then two passes through the restoring divider (one quotient bit per
//   cycle, leg pair 0/3 then leg pair 1/2), a fixup state and an output
//   state. A zero-speed beat goes straight from accept to the output state.
// Reset: synchronous, active low; no clearing pass.
// Stalls: the result sits in the output register until taken; a new beat is
//   accepted and worked on meanwhile, and waits in the output state.
module trot_gait_phase_generator_unit
    import tgpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now_ms, target_speed_mm_s

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // stance_leg0..3, swing_leg0..3

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CMP, S_SETUP, S_DIV, S_STORE, S_FIN, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE, KIND_STANCE, KIND_SWING
    } leg_kind_t;

    // configuration
    logic [STEP_W-1:0]  step_len_reg;
    logic [SWING_W-1:0] swing_per_reg;

    // gait state
    logic [NOW_W-1:0]   touchdown_reg;
    logic               started_reg;
    logic               swung_reg;

    // control
    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               leg_sel_reg;
    leg_kind_t          kind_reg;
    logic               m_tvalid_reg;

    // multiplier
    logic [NOW_W-1:0]   now_reg;
    logic [PROD_W-1:0]  mcand_e_reg;
    logic [WV_W-1:0]    mcand_w_reg;
    logic [SPEED_W-1:0] mplier_reg;
    logic [PROD_W-1:0]  acc_ev_reg;
    logic [WV_W-1:0]    acc_wv_reg;

    // leg clocks, doubled and scaled by speed
    logic signed [C_W-1:0] c0_reg;
    logic signed [C_W-1:0] c1_reg;
    logic signed [C_W-1:0] two_l_reg;
    logic signed [C_W-1:0] two_wv_reg;

    // divider
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dvsr_reg;
    logic [PHASE_W-1:0] quot_reg;

    // leg results; legs 2 and 3 mirror legs 1 and 0
    logic [PHASE_W-1:0] st0_reg, st1_reg, st3_reg, sw0_reg, sw1_reg;
    logic               in_swing0_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // input beat fields
    logic [NOW_W-1:0]   s_now;
    logic [SPEED_W-1:0] s_speed;
    assign s_now   = s_tdata[NOW_W-1:0];
    assign s_speed = s_tdata[NOW_W +: SPEED_W];

    // restart compare and leg clocks
    logic [NOW_W-1:0]      elapsed;
    logic [SUM_W-1:0]      sum_lw;
    logic                  restart;
    logic [PROD_W-1:0]     ev_eff;
    logic signed [C_W-1:0] c0_calc, c1_calc, two_l_calc, two_wv_calc;

    always_comb begin
        elapsed = started_reg ? (s_now - touchdown_reg) : '0;
        sum_lw  = {{(SUM_W-STEP_W){1'b0}}, step_len_reg} + {1'b0, acc_wv_reg};
        restart = acc_ev_reg >= {{(PROD_W-SUM_W){1'b0}}, sum_lw};
        ev_eff  = restart ? '0 : acc_ev_reg;
        c0_calc = $signed({ev_eff[C_W-2:0], 1'b0});
        c1_calc = c0_calc - $signed({{(C_W-SUM_W){1'b0}}, sum_lw});
        two_l_calc  = $signed({{(C_W-STEP_W-1){1'b0}}, step_len_reg, 1'b0});
        two_wv_calc = $signed({{(C_W-WV_W-1){1'b0}}, acc_wv_reg, 1'b0});
    end

    // leg window classification for the selected leg pair
    logic signed [C_W-1:0] c_sel, x_wide, win_end;
    logic                  hit_stance, hit_neg_swing, hit_pos_swing;
    leg_kind_t             kind_calc;
    logic [DIV_W-1:0]      x_calc, d_calc;

    always_comb begin
        c_sel   = leg_sel_reg ? c1_reg : c0_reg;
        win_end = two_l_reg + two_wv_reg;
        hit_stance    = !c_sel[C_W-1] && (c_sel != '0) && (c_sel < two_l_reg);
        hit_neg_swing = c_sel[C_W-1] && (c_sel > -two_wv_reg);
        hit_pos_swing = (c_sel > two_l_reg) && (c_sel < win_end);
        x_wide    = '0;
        d_calc    = DIV_W'(1);
        kind_calc = KIND_NONE;
        if (hit_stance) begin
            x_wide    = c_sel;
            d_calc    = two_l_reg[DIV_W-1:0];
            kind_calc = KIND_STANCE;
        end else if (hit_neg_swing) begin
            x_wide    = c_sel + two_wv_reg;
            d_calc    = two_wv_reg[DIV_W-1:0];
            kind_calc = KIND_SWING;
        end else if (hit_pos_swing) begin
            x_wide    = c_sel - two_l_reg;
            d_calc    = two_wv_reg[DIV_W-1:0];
            kind_calc = KIND_SWING;
        end
        x_calc = x_wide[DIV_W-1:0];
    end

    // restoring divider step
    logic [DIV_W-1:0] rem_dbl, rem_diff;
    logic             rem_ge;

    always_comb begin
        rem_dbl  = {rem_reg[DIV_W-2:0], 1'b0};
        rem_diff = rem_dbl - dvsr_reg;
        rem_ge   = rem_dbl >= dvsr_reg;
    end

    // result of the finished divide, split by window kind
    logic [PHASE_W-1:0] q_stance, q_swing;
    logic               swung_new;

    always_comb begin
        q_stance  = (kind_reg == KIND_STANCE) ? quot_reg : '0;
        q_swing   = (kind_reg == KIND_SWING) ? quot_reg : '0;
        swung_new = swung_reg | in_swing0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            step_len_reg  <= STEP_LENGTH_RST;
            swing_per_reg <= SWING_PERIOD_RST;
            touchdown_reg <= '0;
            started_reg   <= 1'b0;
            swung_reg     <= 1'b0;
            cnt_reg       <= '0;
            leg_sel_reg   <= 1'b0;
            kind_reg      <= KIND_NONE;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_STEP_LENGTH:  step_len_reg  <= cfg_wr_data;
                    REG_SWING_PERIOD: swing_per_reg <= cfg_wr_data[SWING_W-1:0];
                    default: ;
                endcase
            end

            // the output state reloads the beat itself when it is taken
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_speed == '0) begin
                            // stop: clear touchdown and swung, all phases zero
                            touchdown_reg <= '0;
                            swung_reg     <= 1'b0;
                            st0_reg <= '0;
                            st1_reg <= '0;
                            st3_reg <= '0;
                            sw0_reg <= '0;
                            sw1_reg <= '0;
                            state_reg <= S_DONE;
                        end else begin
                            if (!started_reg) begin
                                started_reg   <= 1'b1;
                                touchdown_reg <= s_now;
                            end
                            now_reg     <= s_now;
                            mcand_e_reg <= {{(PROD_W-NOW_W){1'b0}}, elapsed};
                            mcand_w_reg <= {{(WV_W-SWING_W){1'b0}}, swing_per_reg};
                            mplier_reg  <= s_speed;
                            acc_ev_reg  <= '0;
                            acc_wv_reg  <= '0;
                            cnt_reg     <= '0;
                            state_reg   <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    // one speed bit per cycle, LSB first
                    if (mplier_reg[0]) begin
                        acc_ev_reg <= acc_ev_reg + mcand_e_reg;
                        acc_wv_reg <= acc_wv_reg + mcand_w_reg;
                    end
                    mcand_e_reg <= {mcand_e_reg[PROD_W-2:0], 1'b0};
                    mcand_w_reg <= {mcand_w_reg[WV_W-2:0], 1'b0};
                    mplier_reg  <= {1'b0, mplier_reg[SPEED_W-1:1]};
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= S_CMP;
                    end
                end

                S_CMP: begin
                    // stride over: restart at touchdown
                    if (restart) begin
                        touchdown_reg <= now_reg;
                    end
                    c0_reg      <= c0_calc;
                    c1_reg      <= c1_calc;
                    two_l_reg   <= two_l_calc;
                    two_wv_reg  <= two_wv_calc;
                    leg_sel_reg <= 1'b0;
                    state_reg   <= S_SETUP;
                end

                S_SETUP: begin
                    // outside every window: 0 / 1 gives a zero quotient
                    rem_reg   <= x_calc;
                    dvsr_reg  <= d_calc;
                    kind_reg  <= kind_calc;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end

                S_DIV: begin
                    rem_reg  <= rem_ge ? rem_diff : rem_dbl;
                    quot_reg <= {quot_reg[PHASE_W-2:0], rem_ge};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= S_STORE;
                    end
                end

                S_STORE: begin
                    if (!leg_sel_reg) begin
                        st0_reg       <= q_stance;
                        sw0_reg       <= q_swing;
                        in_swing0_reg <= (kind_reg == KIND_SWING);
                        leg_sel_reg   <= 1'b1;
                        state_reg     <= S_SETUP;
                    end else begin
                        st1_reg   <= q_stance;
                        sw1_reg   <= q_swing;
                        state_reg <= S_FIN;
                    end
                end

                S_FIN: begin
                    // before the first swing of leg 0, hold leg 3 at half and leg 0 at half or above
                    swung_reg <= swung_new;
                    if (!swung_new) begin
                        if (st0_reg < PHASE_HALF) begin
                            st0_reg <= PHASE_HALF;
                        end
                        st3_reg <= PHASE_HALF;
                    end else begin
                        st3_reg <= st0_reg;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {sw0_reg, sw1_reg, sw1_reg, sw0_reg,
                                         st3_reg, st1_reg, st1_reg, st0_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/tgpg_checker.sv]
// Port-level checker for the trot gait phase generator, bound to the top.
// Depends on tgpg_pkg and trot_gait_phase_generator_unit.
module tgpg_checker
    import tgpg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one beat in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // legs 1 and 2 share a clock
    a_pair_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] == m_tdata[47:32])
                  && (m_tdata[95:80] == m_tdata[111:96]))
        else $error("legs 1 and 2 differ");

    // no leg is in stance and swing at once
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == '0 || m_tdata[79:64] == '0)
                  && (m_tdata[31:16] == '0 || m_tdata[95:80] == '0)
                  && (m_tdata[63:48] == '0 || m_tdata[127:112] == '0))
        else $error("leg in stance and swing together");

endmodule

bind trot_gait_phase_generator_unit tgpg_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
